@@ sv/rgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgs_pkg
// Shared constants and types for the gray conversion and Sobel gradient block.
// ----------------------------------------------------------------------------
package rgs_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = COL_W + 1;
    localparam int HGT_W  = ROW_W + 1;
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 12;
    localparam int GRAY_W = 24;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;
    localparam int CFG_W    = HGT_W;

    localparam logic [15:0] GRAY_R = 16'd19595;
    localparam logic [15:0] GRAY_G = 16'd38470;
    localparam logic [15:0] GRAY_B = 16'd7471;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } t_line_word;

endpackage

@@ sv/rgb_gray_sobel_gradient.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_sobel_gradient
// Converts raster BGR pixels to gray and gives the 3x3 Sobel X/Y gradient of
// the window centred one row and one column back.
//
//   port group  | direction | contents
//   s_axis_*    | in        | pixel word, tuser = frame_start
//   m_axis_*    | out       | gradient word, tuser = center_valid
//   i_cfg_*     | in        | register writes (width, height)
//
// One pixel per cycle; a stall on m_axis holds the whole pipeline. A result
// passes stage 1 and the output register. The line store is a single memory
// with a registered read: read at acceptance, written back as the pixel leaves
// stage 1, with forwarding for the same column. Reset is synchronous and
// clears counters, window and valid flags; the line store is not cleared.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_gradient (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  rgs_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [rgs_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] pixel_blue, [15:8] pixel_green, [23:16] pixel_red
    input  logic [rgs_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [0] frame_start
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] grad_x, [15:8] grad_y, [26:16] center_col, [38:27] center_row,
    // [39] zero
    output logic [rgs_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // [0] center_valid
    output logic                           m_axis_tuser
);
    import rgs_pkg::*;

    function automatic logic [PIX_W-1:0] div8(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] a;
        a = v[SUM_W-1] ? v + SUM_W'(7) : v;
        return PIX_W'(a >>> 3);
    endfunction

    // configuration
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;

    // counters
    logic [COL_W-1:0] r_col, n_col, col_cur;
    logic [ROW_W-1:0] r_row, n_row, row_cur;
    logic [WID_W-1:0] col_inc;
    logic [HGT_W-1:0] row_inc;

    // stage 1
    logic             r_s1_vld;
    logic [PIX_W-1:0] r_b1, r_g1, r_r1;
    logic [COL_W-1:0] r_c1;
    logic [ROW_W-1:0] r_row1;
    logic             r_fwd;
    t_line_word       r_fwd_q;
    t_line_word       r_mem_q;
    t_line_word       line_rd;

    t_line_word       mem [MAX_WIDTH];

    logic [PIX_W-1:0] r_win [6];

    logic             accept, adv1;
    logic [GRAY_W-1:0] gray_sum;
    logic [PIX_W-1:0] gray, tr, mr;
    logic signed [SUM_W-1:0] s_tl, s_tm, s_tr, s_ml, s_mr, s_bl, s_bm, s_br;
    logic signed [SUM_W-1:0] gx, gy;
    logic             win_ok;
    logic [COL_W-1:0] col_out;
    logic [ROW_W-1:0] row_out;

    // output register
    logic                r_o_vld;
    logic [M_DATA_W-1:0] r_o_data;
    logic                r_o_user;

    always_comb begin
        if (r_width < WID_W'(MIN_SIZE)) begin
            w_eff = WID_W'(MIN_SIZE);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < HGT_W'(MIN_SIZE)) begin
            h_eff = HGT_W'(MIN_SIZE);
        end else if (r_height > HGT_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    always_comb begin
        if (s_axis_tuser || ({1'b0, r_col} >= w_eff)) begin
            col_cur = '0;
        end else begin
            col_cur = r_col;
        end
        if (s_axis_tuser || ({1'b0, r_row} >= h_eff)) begin
            row_cur = '0;
        end else begin
            row_cur = r_row;
        end
        col_inc = {1'b0, col_cur} + WID_W'(1);
        row_inc = {1'b0, row_cur} + HGT_W'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = row_cur;
        end
    end

    assign adv1          = r_s1_vld && (!r_o_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || adv1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        gray_sum = GRAY_W'(r_r1) * GRAY_W'(GRAY_R)
                 + GRAY_W'(r_g1) * GRAY_W'(GRAY_G)
                 + GRAY_W'(r_b1) * GRAY_W'(GRAY_B);
        gray     = gray_sum[GRAY_W-1 -: PIX_W];
        line_rd  = r_fwd ? r_fwd_q : r_mem_q;
        tr       = line_rd.older;
        mr       = line_rd.newer;
        s_tl = $signed(SUM_W'(r_win[0]));
        s_ml = $signed(SUM_W'(r_win[1]));
        s_bl = $signed(SUM_W'(r_win[2]));
        s_tm = $signed(SUM_W'(r_win[3]));
        s_bm = $signed(SUM_W'(r_win[5]));
        s_tr = $signed(SUM_W'(tr));
        s_mr = $signed(SUM_W'(mr));
        s_br = $signed(SUM_W'(gray));
        gx = (s_tr - s_tl) + ((s_mr - s_ml) <<< 1) + (s_br - s_bl);
        gy = (s_bl + (s_bm <<< 1) + s_br) - (s_tl + (s_tm <<< 1) + s_tr);
        win_ok  = (r_row1 >= ROW_W'(2)) && (r_c1 >= COL_W'(2));
        col_out = (r_c1 != '0) ? r_c1 - COL_W'(1) : '0;
        row_out = (r_row1 != '0) ? r_row1 - ROW_W'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(640);
            r_height <= HGT_W'(480);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[WID_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (accept) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_s1_vld <= 1'b1;
                r_fwd    <= adv1 && (col_cur == r_c1);
            end else if (adv1) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b1    <= s_axis_tdata[7:0];
            r_g1    <= s_axis_tdata[15:8];
            r_r1    <= s_axis_tdata[23:16];
            r_c1    <= col_cur;
            r_row1  <= row_cur;
            r_fwd_q <= '{older: mr, newer: gray};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_q <= mem[col_cur];
        end
        if (adv1) begin
            mem[r_c1] <= '{older: mr, newer: gray};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (adv1) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= tr;
            r_win[4] <= mr;
            r_win[5] <= gray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv1) begin
            r_o_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_o_data <= {1'b0, row_out, col_out,
                         win_ok ? div8(gy) : PIX_W'(0),
                         win_ok ? div8(gx) : PIX_W'(0)};
            r_o_user <= win_ok;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

endmodule

@@ verif/rgb_gray_sobel_gradient_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_sobel_gradient_test
// Self-checking bench for the gray conversion and 3x3 Sobel gradient block.
// A behavioral predictor tracks the counters, line stores and window and
// queues one gradient word per accepted pixel word. Stimulus starts with a
// directed table of gray ramps and edges, then runs random frames over many
// image sizes, including the saturating extremes of both size registers.
// Both stream sides idle in random bursts, except in the closing phase.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_gradient_test;
    import rgs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_DIRECTED  = 25;
    localparam int unsigned LUM_R = 19595;
    localparam int unsigned LUM_G = 38470;
    localparam int unsigned LUM_B = 7471;

    typedef struct packed {
        logic        valid;
        logic [11:0] row;
        logic [10:0] col;
        logic [7:0]  gy;
        logic [7:0]  gx;
    } t_gradient;

    typedef struct packed {
        logic [7:0] level;
        logic       frame_start;
        logic       typed;
        t_gradient  want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_idx = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] pixel_blue, [15:8] pixel_green, [23:16] pixel_red
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    // [0] frame_start
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] grad_x, [15:8] grad_y, [26:16] center_col, [38:27] center_row, [39] zero
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // [0] center_valid
    logic                  m_axis_tuser;

    // predictor state
    int unsigned width_reg;
    int unsigned height_reg;
    logic [7:0]  gray_m2 [MAX_WIDTH];
    logic [7:0]  gray_m1 [MAX_WIDTH];
    logic [7:0]  win_px [6];
    int unsigned col_cnt;
    int unsigned row_cnt;

    t_gradient   pending_grads [$];
    t_stim_row   directed_rows [N_DIRECTED];
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          stall_enable = 1'b0;
    bit          feed_gaps = 1'b0;
    t_gradient   got_grad;
    t_gradient   want_grad;

    rgb_gray_sobel_gradient u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_width(input int unsigned w);
        if (w < MIN_SIZE) return MIN_SIZE;
        if (w > MAX_WIDTH) return MAX_WIDTH;
        return w;
    endfunction

    function automatic t_gradient gray_sobel_step(input logic [7:0] blue, input logic [7:0] green,
                                                  input logic [7:0] red, input bit fs);
        int unsigned w, h, c, rw, lum;
        int          tl, tm, tr, ml, mr, bl, bm, br, sx, sy;
        t_gradient   res;
        w = clamp_width(width_reg);
        h = (height_reg < MIN_SIZE) ? MIN_SIZE :
            (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= w) col_cnt = 0;
        if (row_cnt >= h) row_cnt = 0;
        c  = col_cnt;
        rw = row_cnt;
        lum = (red * LUM_R + green * LUM_G + blue * LUM_B) >> 16;

        tl = win_px[0];
        ml = win_px[1];
        bl = win_px[2];
        tm = win_px[3];
        bm = win_px[5];
        tr = gray_m2[c];
        mr = gray_m1[c];
        br = lum;
        sx = ((tr - tl) + 2 * (mr - ml) + (br - bl)) / 8;
        sy = ((bl + 2 * bm + br) - (tl + 2 * tm + tr)) / 8;

        res.valid = (rw >= 2 && c >= 2);
        res.gx    = res.valid ? sx[7:0] : 8'd0;
        res.gy    = res.valid ? sy[7:0] : 8'd0;
        res.col   = (c >= 1) ? 11'(c - 1) : 11'd0;
        res.row   = (rw >= 1) ? 12'(rw - 1) : 12'd0;

        // advance the window one column and refresh the line stores
        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = tr[7:0];
        win_px[4] = mr[7:0];
        win_px[5] = lum[7:0];
        gray_m2[c] = mr[7:0];
        gray_m1[c] = lum[7:0];

        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = rw + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
        return res;
    endfunction

    function automatic t_stim_row dir_row(input logic [7:0] level, input bit fs, input bit typed,
                                          input t_gradient want);
        t_stim_row row;
        row.level       = level;
        row.frame_start = fs;
        row.typed       = typed;
        row.want        = want;
        return row;
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red, input bit fs, input bit typed,
                              input t_gradient want);
        t_gradient predicted;
        if (feed_gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {red, green, blue};
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = gray_sobel_step(blue, green, red, fs);
        pending_grads = {pending_grads, (typed ? want : predicted)};
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        do @(negedge i_clk); while (pending_grads.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = value & 32'hFFF;
        else height_reg = value & 32'h1FFF;
        @(negedge i_clk);
    endtask

    task automatic set_sizes(input int unsigned w, input int unsigned h, output bit grown);
        int unsigned prior;
        prior = clamp_width(width_reg);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        grown = clamp_width(width_reg) > prior;
    endtask

    // a wider row would read line store columns never filled: restart the frame then
    task automatic run_phase(input int n_items, input bit force_start);
        bit fs;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) begin
                s_axis_tvalid <= 1'b0;
                drain_results();
            end
            fs = (i == 0 && force_start) || $urandom_range(0, 39) == 0;
            push_pixel(rand_level(), rand_level(), rand_level(), fs, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        drain_results();
    endtask

    always @(negedge i_clk) begin
        if (!stall_enable) begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_grad = {m_axis_tuser, m_axis_tdata[38:0]};
            if (pending_grads.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= 10)
                    $display("unexpected gradient word: gx=%0d gy=%0d v=%0b col=%0d row=%0d",
                             $signed(got_grad.gx), $signed(got_grad.gy), got_grad.valid,
                             got_grad.col, got_grad.row);
            end else begin
                want_grad = pending_grads.pop_front();
                if (got_grad.gx !== want_grad.gx || got_grad.gy !== want_grad.gy ||
                    got_grad.valid !== want_grad.valid || got_grad.col !== want_grad.col ||
                    got_grad.row !== want_grad.row) begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                        $display({"gradient mismatch: want gx=%0d gy=%0d v=%0b col=%0d row=%0d",
                                  "  got gx=%0d gy=%0d v=%0b col=%0d row=%0d"},
                                 $signed(want_grad.gx), $signed(want_grad.gy), want_grad.valid,
                                 want_grad.col, want_grad.row,
                                 $signed(got_grad.gx), $signed(got_grad.gy), got_grad.valid,
                                 got_grad.col, got_grad.row);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** rgb_gray_sobel_gradient: FAILED **");
            $finish;
        end
    end

    initial begin
        bit grown;
        width_reg  = 640;
        height_reg = 480;
        col_cnt    = 0;
        row_cnt    = 0;
        for (int k = 0; k < MAX_WIDTH; k++) begin
            gray_m2[k] = 8'd0;
            gray_m1[k] = 8'd0;
        end
        for (int k = 0; k < 6; k++) win_px[k] = 8'd0;

        // rows of three at width 3: ramp, ramp, ramp, bright, bright, dark, dark, bright
        directed_rows[0]  = dir_row(8'd255, 1'b0, 1'b1, '0);
        directed_rows[1]  = dir_row(8'd0,   1'b1, 1'b1, '0);
        directed_rows[2]  = dir_row(8'd128, 1'b0, 1'b0, '0);
        directed_rows[3]  = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[4]  = dir_row(8'd0,   1'b0, 1'b0, '0);
        directed_rows[5]  = dir_row(8'd128, 1'b0, 1'b0, '0);
        directed_rows[6]  = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[7]  = dir_row(8'd0,   1'b0, 1'b0, '0);
        directed_rows[8]  = dir_row(8'd128, 1'b0, 1'b0, '0);
        directed_rows[9]  = dir_row(8'd255, 1'b0, 1'b1, {1'b1, 12'd1, 11'd1, 8'd0, 8'd127});
        directed_rows[10] = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[11] = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[12] = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[13] = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[14] = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[15] = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[16] = dir_row(8'd0,   1'b0, 1'b0, '0);
        directed_rows[17] = dir_row(8'd0,   1'b0, 1'b0, '0);
        directed_rows[18] = dir_row(8'd0,   1'b0, 1'b1, {1'b1, 12'd4, 11'd1, 8'h81, 8'd0});
        directed_rows[19] = dir_row(8'd0,   1'b0, 1'b0, '0);
        directed_rows[20] = dir_row(8'd0,   1'b0, 1'b0, '0);
        directed_rows[21] = dir_row(8'd0,   1'b0, 1'b0, '0);
        directed_rows[22] = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[23] = dir_row(8'd255, 1'b0, 1'b0, '0);
        directed_rows[24] = dir_row(8'd255, 1'b0, 1'b1, {1'b1, 12'd6, 11'd1, 8'd127, 8'd0});

        repeat (5) @(negedge i_clk);
        i_rst_n      <= 1'b1;
        stall_enable <= 1'b1;
        feed_gaps    = 1'b1;

        // first word runs at the reset sizes, the rest at 3 x 4096
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (i == 1) begin
                s_axis_tvalid <= 1'b0;
                drain_results();
                set_sizes(0, 8191, grown);
            end
            push_pixel(directed_rows[i].level, directed_rows[i].level, directed_rows[i].level,
                       directed_rows[i].frame_start, directed_rows[i].typed,
                       directed_rows[i].want);
        end
        s_axis_tvalid <= 1'b0;
        drain_results();

        set_sizes(4095, 0, grown);
        run_phase(60, grown);
        set_sizes(2048, 4096, grown);
        run_phase(40, grown);

        repeat (8) begin
            stall_enable <= ($urandom_range(0, 3) != 0);
            feed_gaps    = ($urandom_range(0, 3) != 0);
            set_sizes($urandom_range(1, 12), $urandom_range(1, 8), grown);
            run_phase($urandom_range(30, 50), grown);
        end

        stall_enable <= 1'b0;
        feed_gaps    = 1'b0;
        set_sizes(3, 3, grown);
        run_phase(80, grown);

        repeat (8) @(negedge i_clk);
        if (error_count == 0 && pending_grads.size() == 0) begin
            $display("** rgb_gray_sobel_gradient: PASSED **");
        end else begin
            $display("** rgb_gray_sobel_gradient: FAILED **");
        end
        $finish;
    end

endmodule
